FILE: rtl/log_linear_table_interpolator_unit_macros.svh
// assertion macros for the log-linear table interpolator
`ifndef LOG_LINEAR_TABLE_INTERPOLATOR_UNIT_MACROS_SVH
`define LOG_LINEAR_TABLE_INTERPOLATOR_UNIT_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define LLI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the cycle after the antecedent
`define LLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lli_pkg.sv
`timescale 1ns / 1ps
package lli_pkg;

   // table geometry
   localparam int unsigned DEF_TABLE_DEPTH = 64;
   localparam int COUNT_W = 7;
   localparam int INDEX_W = 6;
   localparam int HEIGHT_W = 32;
   localparam int LOG_W = 32;
   localparam int DENS_W = 48;
   localparam int SCALE_W = 32;

   // shared unit geometry
   localparam int ARITH_W = 64;
   localparam int ARITH_STEPS = 64;
   localparam int ARITH_CNT_W = 7;

   // datapath widths
   localparam int LOGV_W = 44;
   localparam int RED_W = 70;
   localparam int K_W = 7;
   localparam int TERM_W = 5;
   localparam int QF_W = 42;
   localparam int SNUM_W = 57;

   // numeric constants
   localparam int NEAR_LSB = 25;
   localparam logic [63:0] LN2_Q62 = 64'h2C5C_85FD_F473_DE6B;
   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
   localparam logic [63:0] QUOT_CAP = 64'h0000_0200_0000_0000;
   localparam logic [DENS_W-1:0] DENS_MAX = 48'hFFFF_FFFF_FFFF;
   localparam int EXP_HI = 3 * 16777216;
   localparam int EXP_LO = -32 * 16777216;
   localparam int EXP_BIAS = 18;
   localparam int TAYLOR_TERMS = 30;
   localparam logic [SCALE_W-1:0] SCALE_POS_MAX = 32'h7FFF_FFFF;
   localparam logic [SCALE_W-1:0] SCALE_NEG_MAX = 32'h8000_0000;

   // command and status codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_DIV_ZERO = 1'b1;

   typedef enum logic {
      ARITH_MUL,
      ARITH_DIV
   } arith_op_type;

   typedef struct packed {
      logic start;
      arith_op_type op;
   } arith_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_FETCH_HI,
      ST_FETCH_LO,
      ST_PREP,
      ST_CALC,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ROUND,
      ST_SCL_GO,
      ST_SCL_WAIT,
      ST_SCL_FIN,
      ST_EXP_CHK,
      ST_RED,
      ST_TAY_MUL_GO,
      ST_TAY_MUL_WAIT,
      ST_TAY_DIV_GO,
      ST_TAY_DIV_WAIT,
      ST_EXP_FIN,
      ST_DONE
   } seq_state_type;

endpackage

FILE: rtl/lli_channels.sv
`timescale 1ns / 1ps
interface lli_req_if import lli_pkg::*; ();
   logic valid;
   logic ready;
   logic cmd;
   logic [INDEX_W-1:0] entry_index;
   logic signed [HEIGHT_W-1:0] height_value;
   logic signed [LOG_W-1:0] log_density;

   modport source (output valid, cmd, entry_index, height_value, log_density, input ready);
   modport sink (input valid, cmd, entry_index, height_value, log_density, output ready);
endinterface

interface lli_rsp_if import lli_pkg::*; ();
   logic valid;
   logic ready;
   logic [DENS_W-1:0] density;
   logic signed [SCALE_W-1:0] scale_height;
   logic status;

   modport source (output valid, density, scale_height, status, input ready);
   modport sink (input valid, density, scale_height, status, output ready);
endinterface

FILE: rtl/lli_table_mem.sv
`timescale 1ns / 1ps
module lli_table_mem import lli_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int AW = 6
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [HEIGHT_W-1:0] wr_height,
   input  logic [LOG_W-1:0] wr_log,
   input  logic [AW-1:0] rd_addr,
   output logic [HEIGHT_W-1:0] rd_height,
   output logic [LOG_W-1:0] rd_log
);

   logic [HEIGHT_W-1:0] height_mem [TABLE_DEPTH];
   logic [LOG_W-1:0] log_mem [TABLE_DEPTH];
   logic [HEIGHT_W-1:0] rd_height_ff;
   logic [LOG_W-1:0] rd_log_ff;

   // one write port, one registered read port per table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         height_mem[wr_addr] <= wr_height;
         log_mem[wr_addr] <= wr_log;
      end
      rd_height_ff <= height_mem[rd_addr];
      rd_log_ff <= log_mem[rd_addr];
   end

   assign rd_height = rd_height_ff;
   assign rd_log = rd_log_ff;

endmodule

FILE: rtl/lli_arith_unit.sv
`timescale 1ns / 1ps
module lli_arith_unit import lli_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  arith_ctl_type ctl,
   input  logic [ARITH_W-1:0] opa,
   input  logic [ARITH_W-1:0] opb,
   output arith_sts_type sts,
   output logic [2*ARITH_W-1:0] acc,
   output logic [ARITH_W:0] rem
);

   logic [2*ARITH_W-1:0] acc_ff, acc_in;
   logic [ARITH_W:0] rem_ff, rem_in;
   logic [ARITH_W-1:0] opb_ff, opb_in;
   arith_op_type op_ff, op_in;
   logic [ARITH_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [ARITH_W:0] add_a, add_b, shifted;
   logic add_sub;
   logic [ARITH_W+1:0] sum;
   logic ge;

   // operand select for the shared adder
   always_comb begin
      shifted = {rem_ff[ARITH_W-1:0], acc_ff[2*ARITH_W-1]};
      if (op_ff == ARITH_MUL) begin
         add_a = {1'b0, acc_ff[2*ARITH_W-1:ARITH_W]};
         add_b = acc_ff[0] ? {1'b0, opb_ff} : '0;
         add_sub = 1'b0;
      end else begin
         add_a = shifted;
         add_b = {1'b0, opb_ff};
         add_sub = 1'b1;
      end
   end

   // the one wide adder
   assign sum = add_sub ? ({1'b0, add_a} - {1'b0, add_b}) : ({1'b0, add_a} + {1'b0, add_b});
   assign ge = ~sum[ARITH_W+1];

   // shift-add multiply or restoring divide, one bit per cycle
   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      opb_in = opb_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         op_in = ctl.op;
         opb_in = opb;
         rem_in = '0;
         acc_in = (ctl.op == ARITH_MUL) ? {{ARITH_W{1'b0}}, opa} : {opa, {ARITH_W{1'b0}}};
         cnt_in = ARITH_CNT_W'(ARITH_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (op_ff == ARITH_MUL) begin
            acc_in = {sum[ARITH_W:0], acc_ff[ARITH_W-1:1]};
         end else begin
            rem_in = ge ? sum[ARITH_W:0] : shifted;
            acc_in = {acc_ff[2*ARITH_W-2:0], ge};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ARITH_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
         op_ff <= ARITH_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
         op_ff <= op_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      opb_ff <= opb_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign acc = acc_ff;
   assign rem = rem_ff;

endmodule

FILE: rtl/lli_sequencer.sv
`timescale 1ns / 1ps
module lli_sequencer import lli_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int AW = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic [COUNT_W-1:0] entry_count,
   lli_req_if.sink req_if,
   lli_rsp_if.source rsp_if,
   output logic mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [HEIGHT_W-1:0] mem_wr_height,
   output logic [LOG_W-1:0] mem_wr_log,
   output logic [AW-1:0] mem_rd_addr,
   input  logic [HEIGHT_W-1:0] mem_rd_height,
   input  logic [LOG_W-1:0] mem_rd_log,
   output arith_ctl_type arith_ctl,
   output logic [ARITH_W-1:0] arith_opa,
   output logic [ARITH_W-1:0] arith_opb,
   input  arith_sts_type arith_sts,
   input  logic [2*ARITH_W-1:0] arith_acc,
   input  logic [ARITH_W:0] arith_rem
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic signed [RED_W-1:0] LN2_RED = {{(RED_W-64){1'b0}}, LN2_Q62};

   seq_state_type state_ff, state_in;

   logic signed [HEIGHT_W-1:0] h_ff, h_in, h1_ff, h1_in, h0_ff, h0_in;
   logic signed [LOG_W-1:0] l1_ff, l1_in, l0_ff, l0_in;
   logic [CW-1:0] n_ff, n_in, i_ff, i_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [31:0] a_mag_ff, a_mag_in, b_mag_ff, b_mag_in;
   logic [31:0] dh_mag_ff, dh_mag_in, dv_mag_ff, dv_mag_in;
   logic interp_neg_ff, interp_neg_in, dh_neg_ff, dh_neg_in;
   logic dl_neg_ff, dl_neg_in, dl_zero_ff, dl_zero_in;
   logic [SNUM_W-1:0] snum_ff, snum_in;
   logic signed [LOGV_W-1:0] logv_ff, logv_in;
   logic signed [SCALE_W-1:0] scale_ff, scale_in;
   logic status_ff, status_in;
   logic signed [RED_W-1:0] r_ff, r_in;
   logic signed [K_W-1:0] k_ff, k_in;
   logic [63:0] e_ff, e_in, t_ff, t_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic [DENS_W-1:0] dens_ff, dens_in;
   logic out_full_ff, out_full_in;
   logic [DENS_W-1:0] out_dens_ff, out_dens_in;
   logic signed [SCALE_W-1:0] out_scale_ff, out_scale_in;
   logic out_status_ff, out_status_in;

   logic accept, take, out_load;
   logic [31:0] cnt_wide;
   logic [CW-1:0] n_c, lb_c, nm1_c;
   logic hit, last;
   logic signed [32:0] a_s, b_s, dh_s, d_s, dl_s;
   logic [31:0] a_mag_c, b_mag_c, dh_mag_c, dv_mag_c;
   logic near;
   logic q_sat, rnd;
   logic [QF_W-1:0] qf;
   logic signed [LOGV_W-1:0] logv_round;
   logic [SCALE_W-1:0] scale_fin;
   logic red_lt0, red_ge;
   logic signed [7:0] sh_s;
   logic [6:0] shamt;
   logic [64:0] exp_sum, exp_shift;
   logic [DENS_W-1:0] dens_fin;
   logic [63:0] t_new;

   assign accept = req_if.valid && req_if.ready;
   assign take = rsp_if.valid && rsp_if.ready;
   assign out_load = (state_ff == ST_DONE) && (!out_full_ff || take);

   // entry count clamped to the table
   assign cnt_wide = 32'(entry_count);
   assign n_c = (cnt_wide < 32'd2) ? CW'(2) :
                ((cnt_wide > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_wide));

   // search compare and index clamp
   assign hit = $signed(mem_rd_height) >= h_ff;
   assign last = (CW'(i_ff + 1'b1) == n_ff);
   assign nm1_c = CW'(n_ff - 1'b1);
   assign lb_c = hit ? i_ff : n_ff;

   // segment differences and magnitudes
   assign a_s = 33'(h_ff) - 33'(h0_ff);
   assign b_s = 33'(l1_ff) - 33'(l0_ff);
   assign dh_s = 33'(h1_ff) - 33'(h0_ff);
   assign d_s = 33'(h_ff) - 33'(h1_ff);
   assign dl_s = 33'(l0_ff) - 33'(l1_ff);
   assign a_mag_c = a_s[32] ? 32'(-a_s) : a_s[31:0];
   assign b_mag_c = b_s[32] ? 32'(-b_s) : b_s[31:0];
   assign dh_mag_c = dh_s[32] ? 32'(-dh_s) : dh_s[31:0];
   assign dv_mag_c = dl_s[32] ? 32'(-dl_s) : dl_s[31:0];
   assign near = ((d_s <= 33'(NEAR_LSB)) && (d_s >= -33'(NEAR_LSB))) || (h1_ff == h0_ff);

   // interpolation quotient: cap, round half up, apply sign
   assign q_sat = arith_acc > 128'(QUOT_CAP);
   assign rnd = {arith_rem, 1'b0} >= 66'(dh_mag_ff);
   assign qf = q_sat ? QF_W'(QUOT_CAP) : (arith_acc[QF_W-1:0] + QF_W'(rnd));
   assign logv_round = interp_neg_ff ? (LOGV_W'(l0_ff) - LOGV_W'(qf))
                                     : (LOGV_W'(l0_ff) + LOGV_W'(qf));

   // scale height saturation
   always_comb begin
      if (dh_neg_ff ^ dl_neg_ff) begin
         scale_fin = (arith_acc > 128'(SCALE_NEG_MAX)) ? SCALE_NEG_MAX
                                                       : 32'(32'd0 - arith_acc[31:0]);
      end else begin
         scale_fin = (arith_acc > 128'(SCALE_POS_MAX)) ? SCALE_POS_MAX : arith_acc[31:0];
      end
   end

   // range reduction compare
   assign red_lt0 = r_ff[RED_W-1];
   assign red_ge = r_ff >= LN2_RED;

   // final shift of exp into the output format
   assign sh_s = 8'(EXP_BIAS) - 8'(k_ff);
   assign shamt = sh_s[6:0];
   assign exp_sum = {1'b0, e_ff} + (65'd1 << (shamt - 7'd1));
   assign exp_shift = exp_sum >> shamt;
   assign dens_fin = (sh_s >= 8'sd64) ? '0 :
                     ((exp_shift > 65'(DENS_MAX)) ? DENS_MAX : exp_shift[DENS_W-1:0]);

   assign t_new = arith_acc[63:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_if.cmd == CMD_QUERY) state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if (hit || last) state_in = ST_FETCH_HI;
            else state_in = ST_SRCH_RD;
         end
         ST_FETCH_HI: state_in = ST_FETCH_LO;
         ST_FETCH_LO: state_in = ST_PREP;
         ST_PREP: state_in = ST_CALC;
         ST_CALC: begin
            if (!near) state_in = ST_MUL_GO;
            else if (dl_s == 33'sd0) state_in = ST_EXP_CHK;
            else state_in = ST_SCL_GO;
         end
         ST_MUL_GO: state_in = ST_MUL_WAIT;
         ST_MUL_WAIT: begin
            if (arith_sts.done) state_in = ST_DIV_GO;
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (arith_sts.done) state_in = ST_ROUND;
         end
         ST_ROUND: state_in = dl_zero_ff ? ST_EXP_CHK : ST_SCL_GO;
         ST_SCL_GO: state_in = ST_SCL_WAIT;
         ST_SCL_WAIT: begin
            if (arith_sts.done) state_in = ST_SCL_FIN;
         end
         ST_SCL_FIN: state_in = ST_EXP_CHK;
         ST_EXP_CHK: begin
            if (logv_ff > LOGV_W'(EXP_HI) || logv_ff < LOGV_W'(EXP_LO)) state_in = ST_DONE;
            else state_in = ST_RED;
         end
         ST_RED: begin
            if (!red_lt0 && !red_ge) state_in = ST_TAY_MUL_GO;
         end
         ST_TAY_MUL_GO: state_in = ST_TAY_MUL_WAIT;
         ST_TAY_MUL_WAIT: begin
            if (arith_sts.done) state_in = ST_TAY_DIV_GO;
         end
         ST_TAY_DIV_GO: state_in = ST_TAY_DIV_WAIT;
         ST_TAY_DIV_WAIT: begin
            if (arith_sts.done) begin
               if (t_new == 64'd0 || term_ff == TERM_W'(TAYLOR_TERMS)) state_in = ST_EXP_FIN;
               else state_in = ST_TAY_MUL_GO;
            end
         end
         ST_EXP_FIN: state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and port outputs
   always_comb begin
      h_in = h_ff; h1_in = h1_ff; h0_in = h0_ff; l1_in = l1_ff; l0_in = l0_ff;
      n_in = n_ff; i_in = i_ff; idx_in = idx_ff;
      a_mag_in = a_mag_ff; b_mag_in = b_mag_ff; dh_mag_in = dh_mag_ff; dv_mag_in = dv_mag_ff;
      interp_neg_in = interp_neg_ff; dh_neg_in = dh_neg_ff;
      dl_neg_in = dl_neg_ff; dl_zero_in = dl_zero_ff;
      snum_in = snum_ff; logv_in = logv_ff; scale_in = scale_ff; status_in = status_ff;
      r_in = r_ff; k_in = k_ff; e_in = e_ff; t_in = t_ff; term_in = term_ff;
      dens_in = dens_ff;
      mem_rd_addr = '0;
      arith_ctl.start = 1'b0;
      arith_ctl.op = ARITH_MUL;
      arith_opa = '0;
      arith_opb = '0;
      unique case (state_ff)
         ST_IDLE: begin
            h_in = req_if.height_value;
            n_in = n_c;
            i_in = '0;
         end
         ST_SRCH_RD: mem_rd_addr = i_ff[AW-1:0];
         ST_SRCH_CMP: begin
            i_in = CW'(i_ff + 1'b1);
            if (lb_c == '0) idx_in = AW'(1);
            else if (lb_c > nm1_c) idx_in = nm1_c[AW-1:0];
            else idx_in = lb_c[AW-1:0];
         end
         ST_FETCH_HI: mem_rd_addr = idx_ff;
         ST_FETCH_LO: begin
            mem_rd_addr = AW'(idx_ff - 1'b1);
            h1_in = mem_rd_height;
            l1_in = mem_rd_log;
         end
         ST_PREP: begin
            h0_in = mem_rd_height;
            l0_in = mem_rd_log;
         end
         ST_CALC: begin
            a_mag_in = a_mag_c;
            b_mag_in = b_mag_c;
            dh_mag_in = dh_mag_c;
            dv_mag_in = dv_mag_c;
            interp_neg_in = a_s[32] ^ b_s[32] ^ dh_s[32];
            dh_neg_in = dh_s[32];
            dl_neg_in = dl_s[32];
            dl_zero_in = (dl_s == 33'sd0);
            snum_in = {1'b0, dh_mag_c, 24'd0} + SNUM_W'(dv_mag_c[31:1]);
            logv_in = LOGV_W'(l1_ff);
            scale_in = '0;
            status_in = (dl_s == 33'sd0) ? STATUS_DIV_ZERO : STATUS_OK;
         end
         ST_MUL_GO: begin
            arith_ctl.start = 1'b1;
            arith_ctl.op = ARITH_MUL;
            arith_opa = 64'(a_mag_ff);
            arith_opb = 64'(b_mag_ff);
         end
         ST_DIV_GO: begin
            arith_ctl.start = 1'b1;
            arith_ctl.op = ARITH_DIV;
            arith_opa = arith_acc[63:0];
            arith_opb = 64'(dh_mag_ff);
         end
         ST_ROUND: logv_in = logv_round;
         ST_SCL_GO: begin
            arith_ctl.start = 1'b1;
            arith_ctl.op = ARITH_DIV;
            arith_opa = 64'(snum_ff);
            arith_opb = 64'(dv_mag_ff);
         end
         ST_SCL_FIN: scale_in = scale_fin;
         ST_EXP_CHK: begin
            dens_in = (logv_ff > LOGV_W'(EXP_HI)) ? DENS_MAX : '0;
            r_in = RED_W'(logv_ff) <<< 38;
            k_in = '0;
         end
         ST_RED: begin
            if (red_lt0) begin
               r_in = r_ff + LN2_RED;
               k_in = k_ff - 1'b1;
            end else if (red_ge) begin
               r_in = r_ff - LN2_RED;
               k_in = k_ff + 1'b1;
            end
            e_in = ONE_Q62;
            t_in = ONE_Q62;
            term_in = TERM_W'(1);
         end
         ST_TAY_MUL_GO: begin
            arith_ctl.start = 1'b1;
            arith_ctl.op = ARITH_MUL;
            arith_opa = t_ff;
            arith_opb = r_ff[63:0];
         end
         ST_TAY_DIV_GO: begin
            arith_ctl.start = 1'b1;
            arith_ctl.op = ARITH_DIV;
            arith_opa = arith_acc[125:62];
            arith_opb = 64'(term_ff);
         end
         ST_TAY_DIV_WAIT: begin
            if (arith_sts.done) begin
               t_in = t_new;
               if (t_new != 64'd0) e_in = e_ff + t_new;
               term_in = TERM_W'(term_ff + 1'b1);
            end
         end
         ST_EXP_FIN: dens_in = dens_fin;
         default: ;
      endcase
   end

   // output register, filled when it is empty or its result is taken in the same cycle
   always_comb begin
      out_full_in = out_full_ff;
      out_dens_in = out_dens_ff;
      out_scale_in = out_scale_ff;
      out_status_in = out_status_ff;
      if (out_load) begin
         out_full_in = 1'b1;
         out_dens_in = dens_ff;
         out_scale_in = scale_ff;
         out_status_in = status_ff;
      end else if (take) begin
         out_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_full_ff <= out_full_in;
      end
      h_ff <= h_in; h1_ff <= h1_in; h0_ff <= h0_in; l1_ff <= l1_in; l0_ff <= l0_in;
      n_ff <= n_in; i_ff <= i_in; idx_ff <= idx_in;
      a_mag_ff <= a_mag_in; b_mag_ff <= b_mag_in; dh_mag_ff <= dh_mag_in; dv_mag_ff <= dv_mag_in;
      interp_neg_ff <= interp_neg_in; dh_neg_ff <= dh_neg_in;
      dl_neg_ff <= dl_neg_in; dl_zero_ff <= dl_zero_in;
      snum_ff <= snum_in; logv_ff <= logv_in; scale_ff <= scale_in; status_ff <= status_in;
      r_ff <= r_in; k_ff <= k_in; e_ff <= e_in; t_ff <= t_in; term_ff <= term_in;
      dens_ff <= dens_in;
      out_dens_ff <= out_dens_in;
      out_scale_ff <= out_scale_in;
      out_status_ff <= out_status_in;
   end

   // table writes straight from a load beat
   assign mem_wr_en = accept && (req_if.cmd == CMD_LOAD)
                      && (32'(req_if.entry_index) < 32'(TABLE_DEPTH));
   assign mem_wr_addr = AW'(req_if.entry_index);
   assign mem_wr_height = req_if.height_value;
   assign mem_wr_log = req_if.log_density;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = out_full_ff;
   assign rsp_if.density = out_dens_ff;
   assign rsp_if.scale_height = out_scale_ff;
   assign rsp_if.status = out_status_ff;

endmodule

FILE: rtl/log_linear_table_interpolator_unit.sv
`timescale 1ns / 1ps
// channel   dir   payload                                          beat when
// req_if    in    cmd, entry_index, height_value, log_density      valid && ready
// rsp_if    out   density, scale_height, status                    valid && ready
// csr_*     in    entry_count (csr_wr_data)                        csr_wr_en
//
// a load beat is written to the table in the cycle it is taken; ready stays high
// a query runs the search and fetch, then passes of the shared multiply/divide unit
// (up to three passes plus two per series term, up to 30 terms) and range reduction;
// ready stays low from a query until its result is loaded into the output register
// reset is synchronous and clears the sequencer, the unit and the output register
// a result waits in the output register under stall while the next beat is taken
`include "log_linear_table_interpolator_unit_macros.svh"
module log_linear_table_interpolator_unit import lli_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   lli_req_if.sink req_if,
   lli_rsp_if.source rsp_if,
   input  logic csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic mem_wr_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [HEIGHT_W-1:0] mem_wr_height, mem_rd_height;
   logic [LOG_W-1:0] mem_wr_log, mem_rd_log;
   arith_ctl_type arith_ctl;
   arith_sts_type arith_sts;
   logic [ARITH_W-1:0] arith_opa, arith_opb;
   logic [2*ARITH_W-1:0] arith_acc;
   logic [ARITH_W:0] arith_rem;

   // entry count register
   assign entry_count_in = csr_wr_en ? csr_wr_data : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= COUNT_W'(2);
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   lli_table_mem #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .AW(AW)
   ) u_mem (
      .clock(clock),
      .wr_en(mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_height(mem_wr_height),
      .wr_log(mem_wr_log),
      .rd_addr(mem_rd_addr),
      .rd_height(mem_rd_height),
      .rd_log(mem_rd_log)
   );

   lli_arith_unit u_arith (
      .clock(clock),
      .reset(reset),
      .ctl(arith_ctl),
      .opa(arith_opa),
      .opb(arith_opb),
      .sts(arith_sts),
      .acc(arith_acc),
      .rem(arith_rem)
   );

   lli_sequencer #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .AW(AW)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .entry_count(entry_count_ff),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .mem_wr_en(mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_height(mem_wr_height),
      .mem_wr_log(mem_wr_log),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_height(mem_rd_height),
      .mem_rd_log(mem_rd_log),
      .arith_ctl(arith_ctl),
      .arith_opa(arith_opa),
      .arith_opb(arith_opb),
      .arith_sts(arith_sts),
      .arith_acc(arith_acc),
      .arith_rem(arith_rem)
   );

   // checks on the sequencer and the shared unit
   `LLI_ASSERT_NEXT(a_csr_write, clock, reset, csr_wr_en, entry_count_ff == $past(csr_wr_data), "entry count not written")
   `LLI_ASSERT_SAME(a_unit_done_busy, clock, reset, arith_sts.done, !req_if.ready, "shared unit finished while idle")
   `LLI_ASSERT_SAME(a_unit_no_restart, clock, reset, arith_ctl.start, !arith_sts.busy, "shared unit started while busy")

endmodule
